// File: hdl/e820m_pkg.sv
// Shared types, codes and the type classifier for the EFI to e820 merger.
package e820m_pkg;

    localparam int CNT_W           = 8;
    localparam int IDX_W           = 7;
    localparam int CLS_W           = 3;
    localparam int ENTRY_LIMIT_DEF = 128;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_DEPTH       = 4;
    localparam int PAGE_SHIFT      = 12;

    localparam logic [CLS_W-1:0] CLS_RAM      = 3'd0;
    localparam logic [CLS_W-1:0] CLS_ACPI     = 3'd1;
    localparam logic [CLS_W-1:0] CLS_NVS      = 3'd2;
    localparam logic [CLS_W-1:0] CLS_UNUSABLE = 3'd3;
    localparam logic [CLS_W-1:0] CLS_RESERVED = 3'd4;

    localparam logic [31:0] EFI_LOADER_CODE   = 32'd1;
    localparam logic [31:0] EFI_LOADER_DATA   = 32'd2;
    localparam logic [31:0] EFI_BOOT_CODE     = 32'd3;
    localparam logic [31:0] EFI_BOOT_DATA     = 32'd4;
    localparam logic [31:0] EFI_CONVENTIONAL  = 32'd7;
    localparam logic [31:0] EFI_UNUSABLE      = 32'd8;
    localparam logic [31:0] EFI_ACPI_RECLAIM  = 32'd9;
    localparam logic [31:0] EFI_ACPI_NVS      = 32'd10;

    typedef struct packed {
        logic [31:0] desc_type;
        logic [63:0] base_addr;
        logic [51:0] page_count;
        logic        last_descriptor;
    } desc_t;

    typedef struct packed {
        logic [63:0]      entry_addr;
        logic [63:0]      entry_size;
        logic [CLS_W-1:0] entry_class;
        logic [IDX_W-1:0] entry_index;
        logic [CNT_W-1:0] total_entries;
        logic             truncated;
        logic             final_result;
    } entry_t;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [63:0]      start;
        logic [63:0]      size;
        logic             last;
    } cdesc_t;

    function automatic logic [CLS_W-1:0] class_of(input logic [31:0] t);
        logic [CLS_W-1:0] c;
        case (t)
            EFI_LOADER_CODE, EFI_LOADER_DATA, EFI_BOOT_CODE, EFI_BOOT_DATA,
            EFI_CONVENTIONAL: c = CLS_RAM;
            EFI_ACPI_RECLAIM: c = CLS_ACPI;
            EFI_ACPI_NVS:     c = CLS_NVS;
            EFI_UNUSABLE:     c = CLS_UNUSABLE;
            default:          c = CLS_RESERVED;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/e820m_front.sv
// Front part: classify the EFI type and scale the page count to bytes.
module e820m_front (
    input  e820m_pkg::desc_t  desc,
    output e820m_pkg::cdesc_t cdesc
);
    import e820m_pkg::*;

    always_comb
    begin
        cdesc.cls   = class_of(desc.desc_type);
        cdesc.start = desc.base_addr;
        cdesc.size  = {desc.page_count, {PAGE_SHIFT{1'b0}}};
        cdesc.last  = desc.last_descriptor;
    end

endmodule

// File: hdl/e820m_queue.sv
// Short queue of classified descriptors between the front and back parts.
module e820m_queue #(
    parameter int DEPTH = e820m_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  e820m_pkg::cdesc_t wr_data,
    input  logic              wr_valid,
    output logic              wr_stall,
    output e820m_pkg::cdesc_t rd_data,
    output logic              rd_valid,
    input  logic              rd_take
);
    import e820m_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cdesc_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            push, pop;

    assign wr_stall = (cnt_reg == CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && rd_take;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("descriptor queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty descriptor queue with unequal pointers");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("descriptor queue count did not drop on pop");
`endif

endmodule

// File: hdl/e820m_back.sv
// Back part: merge descriptors into the open entry and queue the emitted entries.
module e820m_back #(
    parameter int ENTRY_LIMIT = e820m_pkg::ENTRY_LIMIT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  e820m_pkg::cdesc_t item,
    input  logic              item_valid,
    output logic              item_take,
    output e820m_pkg::entry_t entry,
    output logic              entry_valid,
    input  logic              entry_stall
);
    import e820m_pkg::*;

    localparam int OPW = $clog2(OUT_DEPTH);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic [63:0]      open_addr_reg, open_addr_next;
    logic [63:0]      open_size_reg, open_size_next;
    logic [63:0]      open_end_reg, open_end_next;
    logic [CLS_W-1:0] open_class_reg, open_class_next;
    logic             open_valid_reg, open_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;

    entry_t           omem_reg [OUT_DEPTH];
    logic [OPW-1:0]   head_reg, head_next;
    logic [OPW-1:0]   tail_reg, tail_next;
    logic [OCW-1:0]   ocnt_reg, ocnt_next;

    logic             pop, go, at_limit, merge, emit_open, emit_final;
    logic [OCW-1:0]   occ_after;
    logic [63:0]      new_addr, new_size, new_end;
    logic [CLS_W-1:0] new_class;
    logic             new_valid, new_dropped;
    logic [CNT_W-1:0] new_count;
    entry_t           res_open, res_final;

    assign entry_valid = (ocnt_reg != '0);
    assign entry       = omem_reg[head_reg];
    assign pop         = entry_valid && !entry_stall;
    assign occ_after   = ocnt_reg - OCW'(pop);
    assign go          = item_valid && (occ_after <= OCW'(OUT_DEPTH - 2));
    assign item_take   = go;

    assign at_limit  = (count_reg >= CNT_W'(ENTRY_LIMIT));
    assign merge     = open_valid_reg && (open_class_reg == item.cls) &&
                       (open_end_reg == item.start);
    assign emit_open = !at_limit && !merge && open_valid_reg;

    always_comb
    begin
        new_addr    = open_addr_reg;
        new_size    = open_size_reg;
        new_end     = open_end_reg;
        new_class   = open_class_reg;
        new_valid   = open_valid_reg;
        new_count   = count_reg;
        new_dropped = dropped_reg;
        if (at_limit)
        begin
            new_dropped = 1'b1;
        end
        else if (merge)
        begin
            new_size = open_size_reg + item.size;
            new_end  = open_end_reg + item.size;
        end
        else
        begin
            new_addr  = item.start;
            new_size  = item.size;
            new_end   = item.start + item.size;
            new_class = item.cls;
            new_valid = 1'b1;
            new_count = count_reg + 1'b1;
        end
        emit_final = item.last && new_valid;
    end

    always_comb
    begin
        res_open.entry_addr    = open_addr_reg;
        res_open.entry_size    = open_size_reg;
        res_open.entry_class   = open_class_reg;
        res_open.entry_index   = IDX_W'(count_reg - 1'b1);
        res_open.total_entries = '0;
        res_open.truncated     = 1'b0;
        res_open.final_result  = 1'b0;

        res_final.entry_addr    = new_addr;
        res_final.entry_size    = new_size;
        res_final.entry_class   = new_class;
        res_final.entry_index   = IDX_W'(new_count - 1'b1);
        res_final.total_entries = new_count;
        res_final.truncated     = new_dropped;
        res_final.final_result  = 1'b1;
    end

    always_comb
    begin
        open_addr_next  = open_addr_reg;
        open_size_next  = open_size_reg;
        open_end_next   = open_end_reg;
        open_class_next = open_class_reg;
        open_valid_next = open_valid_reg;
        count_next      = count_reg;
        dropped_next    = dropped_reg;
        tail_next       = tail_reg;
        if (go)
        begin
            open_addr_next  = new_addr;
            open_size_next  = new_size;
            open_end_next   = new_end;
            open_class_next = new_class;
            open_valid_next = new_valid;
            count_next      = new_count;
            dropped_next    = new_dropped;
            if (item.last)
            begin
                open_valid_next = 1'b0;
                count_next      = '0;
                dropped_next    = 1'b0;
            end
            tail_next = tail_reg + OPW'(emit_open) + OPW'(emit_final);
        end
        head_next = head_reg + OPW'(pop);
        ocnt_next = occ_after + (go ? OCW'(emit_open) + OCW'(emit_final) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_valid_reg <= 1'b0;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            ocnt_reg       <= '0;
        end
        else
        begin
            open_valid_reg <= open_valid_next;
            count_reg      <= count_next;
            dropped_reg    <= dropped_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            ocnt_reg       <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        open_addr_reg  <= open_addr_next;
        open_size_reg  <= open_size_next;
        open_end_reg   <= open_end_next;
        open_class_reg <= open_class_next;
        if (go && emit_open)
        begin
            omem_reg[tail_reg] <= res_open;
        end
        if (go && emit_final)
        begin
            omem_reg[tail_reg + OPW'(emit_open)] <= res_final;
        end
    end

`ifndef SYNTHESIS
    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= OCW'(OUT_DEPTH))
        else $error("entry queue count beyond depth");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRY_LIMIT))
        else $error("entry count beyond limit");
    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        open_valid_reg == (count_reg != '0))
        else $error("open entry flag disagrees with entry count");
    a_last_close: assert property (@(posedge clk) disable iff (!rst_n)
        (go && item.last) |=> (!open_valid_reg && !dropped_reg))
        else $error("map state not cleared after last descriptor");
    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        (go && item.last) |-> emit_final)
        else $error("last descriptor without final entry");
`endif

endmodule

// File: hdl/efi_map_to_e820_merger.sv
// Top level of the EFI memory map to e820 table merger.
//
//  channel | dir | payload  | handshake
//  --------+-----+----------+-------------------------------
//  desc    | in  | desc_t   | desc_valid / desc_stall
//  entry   | out | entry_t  | entry_valid / entry_stall
//
//  One descriptor per cycle enters the descriptor queue unless full; the back part
//  takes one per cycle, bounded by a single 64-bit add and compare.
//  Entries leave a four-entry output queue one per cycle unless stalled;
//  a descriptor that closes one entry and ends the map emits two entries.
//  The back part holds while fewer than two output slots are free.
//  Reset empties both queues and closes the open entry; no clearing pass.
module efi_map_to_e820_merger #(
    parameter int ENTRY_LIMIT = e820m_pkg::ENTRY_LIMIT_DEF,
    parameter int QUEUE_DEPTH = e820m_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  e820m_pkg::desc_t  desc,
    input  logic              desc_valid,
    output logic              desc_stall,
    output e820m_pkg::entry_t entry,
    output logic              entry_valid,
    input  logic              entry_stall
);
    import e820m_pkg::*;

    cdesc_t front_cdesc;
    cdesc_t q_data;
    logic   q_valid;
    logic   q_take;

    e820m_front u_front (
        .desc  (desc),
        .cdesc (front_cdesc)
    );

    e820m_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (front_cdesc),
        .wr_valid (desc_valid),
        .wr_stall (desc_stall),
        .rd_data  (q_data),
        .rd_valid (q_valid),
        .rd_take  (q_take)
    );

    e820m_back #(
        .ENTRY_LIMIT (ENTRY_LIMIT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (q_data),
        .item_valid  (q_valid),
        .item_take   (q_take),
        .entry       (entry),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall)
    );

endmodule
